// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while in reset.
`define TMX_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define TMX_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define TMX_ASSERT_IMP(name, clk, rst, ante, cons)
`define TMX_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/tmx_pkg.sv -----
package tmx_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CREEP_SPEED     = 3'd0,
    REG_FULL_SPEED      = 3'd1,
    REG_YAW_SPEED       = 3'd2,
    REG_STOP_WIDTH      = 3'd3,
    REG_STOP_WIDTH_UP   = 3'd4,
    REG_STOP_WIDTH_DOWN = 3'd5,
    REG_REVERSE_GAIN    = 3'd6
  } reg_index_t;

  // Reset values of the registers
  localparam logic [7:0]  RST_CREEP_SPEED = 8'd50;
  localparam logic [7:0]  RST_FULL_SPEED  = 8'd100;
  localparam logic [7:0]  RST_YAW_SPEED   = 8'd50;
  localparam logic [10:0] RST_STOP_WIDTH  = 11'd1500;
  localparam logic [4:0]  RST_REV_GAIN    = 5'd12;

  // Button bit positions
  localparam int unsigned BTN_FWD   = 7;
  localparam int unsigned BTN_BACK  = 6;
  localparam int unsigned BTN_RIGHT = 5;
  localparam int unsigned BTN_LEFT  = 4;
  localparam int unsigned BTN_UP    = 3;
  localparam int unsigned BTN_DOWN  = 2;

  // Rocker codes
  localparam logic [3:0] ROCKER_POS = 4'd3;
  localparam logic [3:0] ROCKER_NEG = 4'd4;

  localparam logic [8:0]         YAW_LEFT_EXTRA = 9'd5;
  localparam logic signed [11:0] HEAVE_BUTTON   = 12'sd100;

  // Pulse width limits
  localparam logic [10:0] LIMIT_LO  = 11'd1300;
  localparam logic [10:0] LIMIT_HI  = 11'd1700;
  localparam logic [10:0] MID_WIDTH = 11'd1500;

  // ceil(2^16 / 10): exact floor division by ten for products below 16384
  localparam logic [12:0] RECIP_DIV10 = 13'd6554;

  // Stage 1 result: motion components and vertical width before limiting
  typedef struct packed {
    logic signed [9:0]  x;
    logic signed [9:0]  y;
    logic signed [9:0]  yaw;
    logic signed [12:0] zn;
  } comp_t;

  // Stage 2 result: limited widths, four horizontal and one vertical
  typedef struct packed {
    logic [10:0] h1;
    logic [10:0] h2;
    logic [10:0] h3;
    logic [10:0] h4;
    logic [10:0] z;
  } width_t;

  // Advance enables of the shaping stages
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
  } shape_adv_t;

endpackage

// ----- hw/rtl/tmx_decode.sv -----
module tmx_decode (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [7:0]           buttons,
  input  logic [3:0]           rocker,
  input  logic                 slow_mode,
  input  logic signed [11:0]   depth_loop_out,
  input  logic [7:0]           creep_speed,
  input  logic [7:0]           full_speed,
  input  logic [7:0]           yaw_speed,
  input  logic [10:0]          stop_width,
  input  logic [10:0]          stop_width_up,
  input  logic [10:0]          stop_width_down,
  output tmx_pkg::comp_t       comp
);

  logic [7:0]         lin;
  logic signed [9:0]  lin_s;
  logic [8:0]         yaw_mag;
  logic signed [11:0] heave;
  logic signed [12:0] heave_ext;
  tmx_pkg::comp_t     comp_next;

  always_comb begin
    lin   = slow_mode ? creep_speed : full_speed;
    lin_s = $signed({2'b00, lin});

    comp_next.x = (buttons[tmx_pkg::BTN_FWD] ? lin_s : 10'sd0)
                - (buttons[tmx_pkg::BTN_BACK] ? lin_s : 10'sd0);
    comp_next.y = (buttons[tmx_pkg::BTN_RIGHT] ? lin_s : 10'sd0)
                - (buttons[tmx_pkg::BTN_LEFT] ? lin_s : 10'sd0);

    // Turning left at full speed gets a small extra push
    if (slow_mode) begin
      yaw_mag = {1'b0, creep_speed};
    end else if (rocker == tmx_pkg::ROCKER_NEG) begin
      yaw_mag = {1'b0, yaw_speed} + tmx_pkg::YAW_LEFT_EXTRA;
    end else begin
      yaw_mag = {1'b0, yaw_speed};
    end

    if (rocker == tmx_pkg::ROCKER_POS) begin
      comp_next.yaw = $signed({1'b0, yaw_mag});
    end else if (rocker == tmx_pkg::ROCKER_NEG) begin
      comp_next.yaw = -$signed({1'b0, yaw_mag});
    end else begin
      comp_next.yaw = 10'sd0;
    end

    // Up wins over down; otherwise follow the depth loop
    if (buttons[tmx_pkg::BTN_UP]) begin
      heave = tmx_pkg::HEAVE_BUTTON;
    end else if (buttons[tmx_pkg::BTN_DOWN]) begin
      heave = -tmx_pkg::HEAVE_BUTTON;
    end else begin
      heave = depth_loop_out;
    end
    heave_ext = {heave[11], heave};

    if (heave > 12'sd0) begin
      comp_next.zn = heave_ext + $signed({2'b00, stop_width_up});
    end else if (heave < 12'sd0) begin
      comp_next.zn = heave_ext + $signed({2'b00, stop_width_down});
    end else begin
      comp_next.zn = $signed({2'b00, stop_width});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      comp <= comp_next;
    end
  end

endmodule

// ----- hw/rtl/tmx_mix.sv -----
module tmx_mix (
  input  logic            clk,
  input  logic            adv,
  input  tmx_pkg::comp_t  comp,
  input  logic [10:0]     stop_width,
  output tmx_pkg::width_t width
);

  logic signed [12:0] x13;
  logic signed [12:0] y13;
  logic signed [12:0] yaw13;
  logic signed [12:0] stop13;
  tmx_pkg::width_t    width_next;

  function automatic logic [10:0] limit_width(input logic signed [12:0] s);
    logic [10:0] r;
    if (s < $signed({2'b00, tmx_pkg::LIMIT_LO})) begin
      r = tmx_pkg::LIMIT_LO;
    end else if (s > $signed({2'b00, tmx_pkg::LIMIT_HI})) begin
      r = tmx_pkg::LIMIT_HI;
    end else begin
      r = s[10:0];
    end
    return r;
  endfunction

  always_comb begin
    x13    = {{3{comp.x[9]}}, comp.x};
    y13    = {{3{comp.y[9]}}, comp.y};
    yaw13  = {{3{comp.yaw[9]}}, comp.yaw};
    stop13 = $signed({2'b00, stop_width});

    width_next.h1 = limit_width(x13 - y13 + yaw13 + stop13);
    width_next.h2 = limit_width(x13 + y13 - yaw13 + stop13);
    width_next.h3 = limit_width(stop13 - x13 - y13 - yaw13);
    width_next.h4 = limit_width(y13 - x13 + yaw13 + stop13);
    width_next.z  = limit_width(comp.zn);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      width <= width_next;
    end
  end

endmodule

// ----- hw/rtl/tmx_shape.sv -----
module tmx_shape (
  input  logic                clk,
  input  tmx_pkg::shape_adv_t adv,
  input  logic [10:0]         width_in,
  input  logic [4:0]          gain,
  output logic [10:0]         width_out
);

  logic [10:0] below_full;
  logic [12:0] prod_next;
  logic [25:0] recip_prod;

  logic        low3;
  logic [10:0] w3;
  logic [12:0] prod3;
  logic        low4;
  logic [10:0] w4;
  logic [9:0]  quot4;

  always_comb begin
    below_full = tmx_pkg::MID_WIDTH - width_in;
    prod_next  = {5'b0, below_full[7:0]} * {8'b0, gain};
    recip_prod = {13'b0, prod3} * {13'b0, tmx_pkg::RECIP_DIV10};
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      low3  <= (width_in < tmx_pkg::MID_WIDTH);
      w3    <= width_in;
      prod3 <= prod_next;
    end
    if (adv.s4) begin
      low4  <= low3;
      w4    <= w3;
      quot4 <= recip_prod[25:16];
    end
    if (adv.s5) begin
      width_out <= low4 ? (tmx_pkg::MID_WIDTH - {1'b0, quot4}) : w4;
    end
  end

endmodule

// ----- hw/rtl/thruster_mixer_with_limits_unit.sv -----
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------
// in       | sink      | in_valid / in_ready    | buttons, rocker, slow_mode,
//          |           |                        | depth_loop_out
// out      | source    | out_valid / out_ready  | drive_h1..drive_h4, drive_z1..z4
// cfg      | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Five register stages: decode, mix and limit, gain multiply, reciprocal divide by ten,
// final subtract. One transaction may enter every cycle while in_ready is high; out_valid
// rises once it has passed every stage. The two multipliers set the critical path.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults.
// An out stall holds every full stage; ready ripples back, so empty stages still fill.
// cfg_ready is always high; writes are expected only while the pipeline is empty.
`include "assert_macros.svh"

module thruster_mixer_with_limits_unit (
  input  logic               clk,
  input  logic               rst,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         buttons,
  input  logic [3:0]         rocker,
  input  logic               slow_mode,
  input  logic signed [11:0] depth_loop_out,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [10:0]        drive_h1,
  output logic [10:0]        drive_h2,
  output logic [10:0]        drive_h3,
  output logic [10:0]        drive_h4,
  output logic [10:0]        drive_z1,
  output logic [10:0]        drive_z2,
  output logic [10:0]        drive_z3,
  output logic [10:0]        drive_z4,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [10:0]        cfg_data
);

  // Configuration registers
  logic [7:0]  creep_speed;
  logic [7:0]  full_speed;
  logic [7:0]  yaw_speed;
  logic [10:0] stop_width;
  logic [10:0] stop_width_up;
  logic [10:0] stop_width_down;
  logic [4:0]  reverse_gain_tenths;

  // Stage valid bits and advance enables
  logic [5:1] vld;
  logic [5:1] adv;

  tmx_pkg::comp_t      comp;
  tmx_pkg::width_t     width;
  tmx_pkg::shape_adv_t shape_adv;
  logic [10:0]         drive_z;

  assign cfg_ready = 1'b1;

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      creep_speed         <= tmx_pkg::RST_CREEP_SPEED;
      full_speed          <= tmx_pkg::RST_FULL_SPEED;
      yaw_speed           <= tmx_pkg::RST_YAW_SPEED;
      stop_width          <= tmx_pkg::RST_STOP_WIDTH;
      stop_width_up       <= tmx_pkg::RST_STOP_WIDTH;
      stop_width_down     <= tmx_pkg::RST_STOP_WIDTH;
      reverse_gain_tenths <= tmx_pkg::RST_REV_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tmx_pkg::REG_CREEP_SPEED:     creep_speed         <= cfg_data[7:0];
        tmx_pkg::REG_FULL_SPEED:      full_speed          <= cfg_data[7:0];
        tmx_pkg::REG_YAW_SPEED:       yaw_speed           <= cfg_data[7:0];
        tmx_pkg::REG_STOP_WIDTH:      stop_width          <= cfg_data;
        tmx_pkg::REG_STOP_WIDTH_UP:   stop_width_up       <= cfg_data;
        tmx_pkg::REG_STOP_WIDTH_DOWN: stop_width_down     <= cfg_data;
        tmx_pkg::REG_REVERSE_GAIN:    reverse_gain_tenths <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // A stage advances when it is empty or the stage after it advances
  always_comb begin
    adv[5] = !vld[5] || out_ready;
    adv[4] = !vld[4] || adv[5];
    adv[3] = !vld[3] || adv[4];
    adv[2] = !vld[2] || adv[3];
    adv[1] = !vld[1] || adv[2];
  end

  assign in_ready  = adv[1];
  assign out_valid = vld[5];

  // Advance the valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= in_valid;
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
      if (adv[4]) vld[4] <= vld[3];
      if (adv[5]) vld[5] <= vld[4];
    end
  end

  // Stage 1: button and rocker decode, heave select and vertical offset
  tmx_decode u_decode (
    .clk             (clk),
    .adv             (adv[1]),
    .buttons         (buttons),
    .rocker          (rocker),
    .slow_mode       (slow_mode),
    .depth_loop_out  (depth_loop_out),
    .creep_speed     (creep_speed),
    .full_speed      (full_speed),
    .yaw_speed       (yaw_speed),
    .stop_width      (stop_width),
    .stop_width_up   (stop_width_up),
    .stop_width_down (stop_width_down),
    .comp            (comp)
  );

  // Stage 2: horizontal mixes and limiting of all five widths
  tmx_mix u_mix (
    .clk        (clk),
    .adv        (adv[2]),
    .comp       (comp),
    .stop_width (stop_width),
    .width      (width)
  );

  assign shape_adv.s3 = adv[3];
  assign shape_adv.s4 = adv[4];
  assign shape_adv.s5 = adv[5];

  // Stages 3 to 5: expand widths below mid-point, one lane per width
  tmx_shape u_shape_h1 (
    .clk (clk), .adv (shape_adv), .width_in (width.h1),
    .gain (reverse_gain_tenths), .width_out (drive_h1)
  );
  tmx_shape u_shape_h2 (
    .clk (clk), .adv (shape_adv), .width_in (width.h2),
    .gain (reverse_gain_tenths), .width_out (drive_h2)
  );
  tmx_shape u_shape_h3 (
    .clk (clk), .adv (shape_adv), .width_in (width.h3),
    .gain (reverse_gain_tenths), .width_out (drive_h3)
  );
  tmx_shape u_shape_h4 (
    .clk (clk), .adv (shape_adv), .width_in (width.h4),
    .gain (reverse_gain_tenths), .width_out (drive_h4)
  );
  tmx_shape u_shape_z (
    .clk (clk), .adv (shape_adv), .width_in (width.z),
    .gain (reverse_gain_tenths), .width_out (drive_z)
  );

  // All four vertical thrusters share one width
  assign drive_z1 = drive_z;
  assign drive_z2 = drive_z;
  assign drive_z3 = drive_z;
  assign drive_z4 = drive_z;

  // An empty output stage lets the whole pipeline take a transaction
  `TMX_ASSERT_IMP(a_empty_out_ready, clk, rst, !out_valid, in_ready)
  // A full pipeline with a stalled output must refuse input
  `TMX_ASSERT_IMP(a_full_stall_block, clk, rst, (&vld) && !out_ready, !in_ready)
  // A held middle stage keeps its transaction
  `TMX_ASSERT_NXT(a_mid_stage_hold, clk, rst, vld[3] && !adv[3], vld[3])
  // Limiting and expansion bound every width from above; drive_h1 and drive_z1 are checked
  `TMX_ASSERT_IMP(a_width_bound, clk, rst, out_valid,
                  (drive_h1 <= tmx_pkg::LIMIT_HI) && (drive_z1 <= tmx_pkg::LIMIT_HI))

endmodule

// ----- dv/tb.sv -----
module tb;

  // Pulse width limits as plain integers, so that signed mixes compare correctly
  localparam int WIDTH_LO  = int'(tmx_pkg::LIMIT_LO);
  localparam int WIDTH_HI  = int'(tmx_pkg::LIMIT_HI);
  localparam int WIDTH_MID = int'(tmx_pkg::MID_WIDTH);

  // Button masks built from the package bit positions
  localparam logic [7:0] PRESS_NONE  = 8'h00;
  localparam logic [7:0] PRESS_FWD   = 8'h01 << tmx_pkg::BTN_FWD;
  localparam logic [7:0] PRESS_BACK  = 8'h01 << tmx_pkg::BTN_BACK;
  localparam logic [7:0] PRESS_RIGHT = 8'h01 << tmx_pkg::BTN_RIGHT;
  localparam logic [7:0] PRESS_LEFT  = 8'h01 << tmx_pkg::BTN_LEFT;
  localparam logic [7:0] PRESS_UP    = 8'h01 << tmx_pkg::BTN_UP;
  localparam logic [7:0] PRESS_DOWN  = 8'h01 << tmx_pkg::BTN_DOWN;
  localparam logic [7:0] PRESS_SPARE = 8'h03;  // bits the block ignores
  localparam logic [7:0] PRESS_ALL   = 8'hFF;

  // Rocker codes that turn nothing
  localparam logic [3:0] ROCKER_IDLE  = 4'd0;
  localparam logic [3:0] ROCKER_OTHER = 4'hF;

  // Register index past the end of the list: writes there must be ignored
  localparam logic [2:0] CFG_IDX_SPARE = 3'd7;

  localparam int LIMIT_TIME = 4_000_000;

  typedef struct packed {
    logic [7:0]         buttons;
    logic [3:0]         rocker;
    logic               slow_mode;
    logic signed [11:0] depth;
  } command_t;

  typedef struct packed {
    logic [10:0] slow_spd;
    logic [10:0] full_spd;
    logic [10:0] yaw_spd;
    logic [10:0] stop_w;
    logic [10:0] stop_up;
    logic [10:0] stop_dn;
    logic [10:0] gain;
  } reg_set_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         buttons = '0;
  logic [3:0]         rocker = '0;
  logic               slow_mode = 1'b0;
  logic signed [11:0] depth_loop_out = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [10:0]        drive_h1, drive_h2, drive_h3, drive_h4;
  logic [10:0]        drive_z1, drive_z2, drive_z3, drive_z4;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [10:0]        cfg_data = '0;

  // Shadow copy of the thruster settings, loaded with the reset values
  int slow_spd = int'(tmx_pkg::RST_CREEP_SPEED);
  int full_spd = int'(tmx_pkg::RST_FULL_SPEED);
  int yaw_spd  = int'(tmx_pkg::RST_YAW_SPEED);
  int stop_w   = int'(tmx_pkg::RST_STOP_WIDTH);
  int stop_up  = int'(tmx_pkg::RST_STOP_WIDTH);
  int stop_dn  = int'(tmx_pkg::RST_STOP_WIDTH);
  int gain     = int'(tmx_pkg::RST_REV_GAIN);

  // Flow-control pressure, in percent, for the current phase
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  tmx_pkg::width_t expected_drives[$];
  int     commands_sent    = 0;
  int     results_checked  = 0;
  int     settings_applied = 0;
  int     mismatches       = 0;

  thruster_mixer_with_limits_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .buttons(buttons), .rocker(rocker), .slow_mode(slow_mode),
    .depth_loop_out(depth_loop_out),
    .out_valid(out_valid), .out_ready(out_ready),
    .drive_h1(drive_h1), .drive_h2(drive_h2), .drive_h3(drive_h3), .drive_h4(drive_h4),
    .drive_z1(drive_z1), .drive_z2(drive_z2), .drive_z3(drive_z3), .drive_z4(drive_z4),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Clamp to the pulse limits, then stretch anything below mid by the gain
  function automatic logic [10:0] limit_and_expand(input int w);
    int v;
    v = w;
    if (v < WIDTH_LO) v = WIDTH_LO;
    if (v > WIDTH_HI) v = WIDTH_HI;
    if (v < WIDTH_MID) v = WIDTH_MID - ((WIDTH_MID - v) * gain) / 10;
    return v[10:0];
  endfunction

  // Work out the five pulse widths (four horizontal, one shared vertical) one command should produce
  function automatic tmx_pkg::width_t predict_drives(input command_t c);
    tmx_pkg::width_t d;
    int lin, x, y, yaw, z, zn;
    lin = c.slow_mode ? slow_spd : full_spd;
    x = 0;
    y = 0;
    yaw = 0;
    if (c.buttons[tmx_pkg::BTN_FWD])   x += lin;
    if (c.buttons[tmx_pkg::BTN_BACK])  x -= lin;
    if (c.buttons[tmx_pkg::BTN_RIGHT]) y += lin;
    if (c.buttons[tmx_pkg::BTN_LEFT])  y -= lin;
    // Yaw-left in full mode picks up the extra offset; slow mode is symmetric
    if (c.rocker == tmx_pkg::ROCKER_POS)
      yaw = c.slow_mode ? slow_spd : yaw_spd;
    else if (c.rocker == tmx_pkg::ROCKER_NEG)
      yaw = c.slow_mode ? -slow_spd : -yaw_spd - int'(tmx_pkg::YAW_LEFT_EXTRA);
    // Heave buttons override the depth loop, and up beats down
    if (c.buttons[tmx_pkg::BTN_UP])        z = int'(tmx_pkg::HEAVE_BUTTON);
    else if (c.buttons[tmx_pkg::BTN_DOWN]) z = -int'(tmx_pkg::HEAVE_BUTTON);
    else                                   z = int'(c.depth);
    if (z > 0)      zn = z + stop_up;
    else if (z < 0) zn = z + stop_dn;
    else            zn = stop_w;
    d.h1 = limit_and_expand(x - y + yaw + stop_w);
    d.h2 = limit_and_expand(x + y - yaw + stop_w);
    d.h3 = limit_and_expand(-x - y - yaw + stop_w);
    d.h4 = limit_and_expand(y - x + yaw + stop_w);
    d.z  = limit_and_expand(zn);
    return d;
  endfunction

  function automatic command_t make_cmd(input logic [7:0] b, input logic [3:0] r,
                                        input logic s, input int depth);
    command_t c;
    c.buttons = b;
    c.rocker = r;
    c.slow_mode = s;
    c.depth = 12'(depth);
    return c;
  endfunction

  // Lean towards real rocker codes and the depth-loop path, with the odd extreme
  function automatic command_t random_cmd();
    command_t c;
    c.buttons = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 0) begin
      c.buttons[tmx_pkg::BTN_UP] = 1'b0;
      c.buttons[tmx_pkg::BTN_DOWN] = 1'b0;
    end
    case ($urandom_range(0, 4))
      0, 1:    c.rocker = tmx_pkg::ROCKER_POS;
      2, 3:    c.rocker = tmx_pkg::ROCKER_NEG;
      default: c.rocker = 4'($urandom_range(0, 15));
    endcase
    c.slow_mode = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0, 1:    c.depth = 12'(int'($urandom_range(0, 500)) - 250);
      2:       c.depth = 12'(int'($urandom_range(0, 8)) - 4);
      3:       c.depth = $urandom_range(0, 1) ? 12'sh7FF : 12'sh800;
      default: c.depth = 12'($urandom_range(0, 4095));
    endcase
    return c;
  endfunction

  function automatic reg_set_t make_set(input int s, input int f, input int y, input int sw,
                                        input int su, input int sd, input int g);
    reg_set_t r;
    r.slow_spd = 11'(s);
    r.full_spd = 11'(f);
    r.yaw_spd = 11'(y);
    r.stop_w = 11'(sw);
    r.stop_up = 11'(su);
    r.stop_dn = 11'(sd);
    r.gain = 11'(g);
    return r;
  endfunction

  // Pick a value in range, landing on either end one time in four
  function automatic int pick_in_range(input int lo, input int hi);
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      default: return int'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic reg_set_t random_set();
    return make_set(pick_in_range(0, 200), pick_in_range(0, 200), pick_in_range(0, 200),
                    pick_in_range(1000, 2000), pick_in_range(1000, 2000),
                    pick_in_range(1000, 2000), pick_in_range(10, 20));
  endfunction

  task automatic report_mismatch(input string what, input logic [10:0] got,
                                 input logic [10:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Write one register; the shadow copy keeps only the register's own width
  task automatic write_reg(input logic [2:0] idx, input logic [10:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    case (idx)
      tmx_pkg::REG_CREEP_SPEED:     slow_spd = int'(data[7:0]);
      tmx_pkg::REG_FULL_SPEED:      full_spd = int'(data[7:0]);
      tmx_pkg::REG_YAW_SPEED:       yaw_spd = int'(data[7:0]);
      tmx_pkg::REG_STOP_WIDTH:      stop_w = int'(data);
      tmx_pkg::REG_STOP_WIDTH_UP:   stop_up = int'(data);
      tmx_pkg::REG_STOP_WIDTH_DOWN: stop_dn = int'(data);
      tmx_pkg::REG_REVERSE_GAIN:    gain = int'(data[4:0]);
      default: ;
    endcase
  endtask

  // Load a full register set, plus a stray write to the unused index
  task automatic program_regs(input reg_set_t s);
    write_reg(tmx_pkg::REG_CREEP_SPEED, s.slow_spd);
    write_reg(tmx_pkg::REG_FULL_SPEED, s.full_spd);
    write_reg(tmx_pkg::REG_YAW_SPEED, s.yaw_spd);
    write_reg(tmx_pkg::REG_STOP_WIDTH, s.stop_w);
    write_reg(tmx_pkg::REG_STOP_WIDTH_UP, s.stop_up);
    write_reg(tmx_pkg::REG_STOP_WIDTH_DOWN, s.stop_dn);
    write_reg(tmx_pkg::REG_REVERSE_GAIN, s.gain);
    write_reg(CFG_IDX_SPARE, 11'($urandom_range(0, 2047)));
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // Offer one command, optionally after an idle gap, and hold it until taken.
  // Valid stays high between back-to-back commands so it is never dropped and
  // raised within one time step.
  task automatic send_cmd(input command_t c);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    buttons <= c.buttons;
    rocker <= c.rocker;
    slow_mode <= c.slow_mode;
    depth_loop_out <= c.depth;
    // Inputs only move at the rising edge, so a ready seen at the falling edge
    // means the transaction completes at the next rising edge
    do @(negedge clk); while (!in_ready);
    expected_drives.push_back(predict_drives(c));
    commands_sent++;
    @(posedge clk);
  endtask

  // Drop valid and wait for the pipeline to empty before touching registers
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Reset values, every button, both rocker turns, heave priority, depth extremes
  task automatic test_reset_defaults();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_cmd(make_cmd(PRESS_NONE, ROCKER_IDLE, 1'b0, 0));
    send_cmd(make_cmd(PRESS_FWD, ROCKER_IDLE, 1'b0, 0));
    send_cmd(make_cmd(PRESS_BACK, ROCKER_IDLE, 1'b1, 0));
    send_cmd(make_cmd(PRESS_RIGHT, tmx_pkg::ROCKER_POS, 1'b0, 0));
    send_cmd(make_cmd(PRESS_LEFT, tmx_pkg::ROCKER_NEG, 1'b0, 0));
    // opposite buttons cancel each other
    send_cmd(make_cmd(PRESS_FWD | PRESS_BACK, ROCKER_IDLE, 1'b0, 0));
    send_cmd(make_cmd(PRESS_RIGHT | PRESS_LEFT, tmx_pkg::ROCKER_POS, 1'b1, 0));
    // heave buttons override the depth loop; up beats down
    send_cmd(make_cmd(PRESS_UP, ROCKER_IDLE, 1'b0, -2048));
    send_cmd(make_cmd(PRESS_DOWN, ROCKER_IDLE, 1'b0, 2047));
    send_cmd(make_cmd(PRESS_UP | PRESS_DOWN, tmx_pkg::ROCKER_NEG, 1'b1, 0));
    send_cmd(make_cmd(PRESS_SPARE, ROCKER_OTHER, 1'b0, 0));
    send_cmd(make_cmd(PRESS_NONE, ROCKER_IDLE, 1'b0, 2047));
    send_cmd(make_cmd(PRESS_NONE, ROCKER_IDLE, 1'b0, -2048));
    send_cmd(make_cmd(PRESS_NONE, ROCKER_IDLE, 1'b1, 1));
    send_cmd(make_cmd(PRESS_NONE, ROCKER_IDLE, 1'b1, -1));
    // yaw-left gets the extra offset only at full speed
    send_cmd(make_cmd(PRESS_NONE, tmx_pkg::ROCKER_NEG, 1'b1, 0));
    send_cmd(make_cmd(PRESS_NONE, tmx_pkg::ROCKER_POS, 1'b1, 0));
    send_cmd(make_cmd(PRESS_NONE, tmx_pkg::ROCKER_NEG, 1'b0, 0));
    send_cmd(make_cmd(PRESS_ALL, ROCKER_OTHER, 1'b1, -2048));
    send_cmd(make_cmd(PRESS_FWD | PRESS_RIGHT, tmx_pkg::ROCKER_POS, 1'b0, 200));
    send_cmd(make_cmd(PRESS_BACK | PRESS_LEFT, tmx_pkg::ROCKER_NEG, 1'b0, -200));
    send_cmd(make_cmd(PRESS_BACK | PRESS_RIGHT, tmx_pkg::ROCKER_NEG, 1'b0, -3));
  endtask

  // Range ends, values past the stated range, and a zero gain
  task automatic test_register_extremes();
    reg_set_t sets[5];
    sets[0] = make_set(0, 0, 0, 1000, 1000, 1000, 10);
    sets[1] = make_set(200, 200, 200, 2000, 2000, 2000, 20);
    sets[2] = make_set(2047, 2047, 2047, 2047, 2047, 2047, 31);
    sets[3] = make_set(0, 0, 0, 0, 0, 0, 0);
    sets[4] = make_set(200, 10, 200, 2000, 1000, 2000, 15);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    foreach (sets[i]) begin
      wait_drained();
      program_regs(sets[i]);
      repeat (20) send_cmd(random_cmd());
    end
  endtask

  // Random commands under fresh random settings, at the given pressure
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    src_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (3) begin
      wait_drained();
      program_regs(random_set());
      repeat (110) send_cmd(random_cmd());
    end
  endtask

  // Backpressure: stall the result channel at random in the current phase
  always @(posedge clk) begin
    out_ready <= (sink_stall_pct == 0) || ($urandom_range(0, 99) >= sink_stall_pct);
  end

  task automatic check_field(input string what, input logic [10:0] got,
                             input logic [10:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Compare every completed result transaction with the oldest prediction
  always @(negedge clk) begin : check_results
    tmx_pkg::width_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_drives.size() == 0) begin
        report_mismatch("unexpected result (drive_h1 shown)", drive_h1, '0);
      end else begin
        want = expected_drives.pop_front();
        check_field("drive_h1", drive_h1, want.h1);
        check_field("drive_h2", drive_h2, want.h2);
        check_field("drive_h3", drive_h3, want.h3);
        check_field("drive_h4", drive_h4, want.h4);
        check_field("drive_z1", drive_z1, want.z);
        check_field("drive_z2", drive_z2, want.z);
        check_field("drive_z3", drive_z3, want.z);
        check_field("drive_z4", drive_z4, want.z);
        results_checked++;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(47, 0);
    test_random_traffic(0, 47);
    test_random_traffic(31, 31);
    // Hold until the last result is out, then allow the pipeline depth again
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Mixer run: %0d commands, %0d results compared, %0d register settings,",
             commands_sent, results_checked, settings_applied);
    $display("  four flow-control regimes, %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost result ends up here
  initial begin
    #LIMIT_TIME;
    $display("Timed out with %0d results still pending.", expected_drives.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
